### rtl/uad_pkg.sv
// ----------------------------------------------------------------------------
// uad_pkg: shared types and constants for unsigned_to_ascii_digits
// Beat types, controller/datapath command and status bundles, and the
// digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package uad_pkg;

    localparam int VALUE_WIDTH = 32;

    // Number of decimal digits of 2**VALUE_WIDTH - 1 (30103 / 100000 ~ log10(2)).
    localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int MAX_DIGITS  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W       = MAX_DIGITS * 4;
    localparam int DAB_W       = DEC_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] OP_DEC       = 2'd0;
    localparam logic [1:0] OP_HEX_LOWER = 2'd1;
    localparam logic [1:0] OP_HEX_UPPER = 2'd2;

    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_LOWER = 7'h57;  // 'a' - 10
    localparam logic [6:0] ASCII_UPPER = 7'h37;  // 'A' - 10

    typedef struct packed {
        logic [1:0]             op;
        logic [VALUE_WIDTH-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic align;
        logic shift;
    } dp_cmd_t;

    typedef struct packed {
        logic is_dec;
        logic bits_done;
        logic top_zero;
        logic one_left;
    } dp_status_t;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit,
                                                  input logic       upper);
        logic [6:0] base;
        if (digit < 4'd10) begin
            base = ASCII_ZERO;
        end else if (upper) begin
            base = ASCII_UPPER;
        end else begin
            base = ASCII_LOWER;
        end
        return 7'(base + {3'b000, digit});
    endfunction

endpackage

### rtl/unsigned_to_ascii_digits.sv
// Sequence: decimal values are loaded, converted one value bit per step in the dabble state,
// aligned, stripped of up to nine leading zeros in the skip state and then emitted.
// Hex values are loaded, pass the dabble state unconverted, drop up to seven zeros and emit.
// Flow: one value at a time, taken only in idle, and output stalls hold the emit state;
// skipped and emitted digits always total ten for decimal and eight for hex.
// Reset: synchronous active-low aresetn returns the sequencer to idle.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits: unsigned value to ASCII digit stream
// Converts a value to decimal, lowercase hex or uppercase hex characters,
// most significant first, leading zeros removed, last beat flagged.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  uad_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output uad_pkg::out_beat_t m_data
);

    uad_pkg::dp_cmd_t    cmd;
    uad_pkg::dp_status_t status;

    uad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    uad_dp u_dp (
        .aclk     (aclk),
        .in_beat  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_beat (m_data)
    );

endmodule

### rtl/uad_ctrl.sv
// ----------------------------------------------------------------------------
// uad_ctrl: conversion sequencer
// Steps each value through load, binary-to-BCD conversion, leading zero
// skipping and character output.
// ----------------------------------------------------------------------------
module uad_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  uad_pkg::dp_status_t status,
    output uad_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DABBLE = 4'b0010,
        ST_SKIP   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DABBLE;
                end
            end
            ST_DABBLE: begin
                // Hex values skip conversion; the digits are already nibbles.
                if (!status.is_dec) begin
                    state_next = ST_SKIP;
                end else if (status.bits_done) begin
                    cmd.align  = 1'b1;
                    state_next = ST_SKIP;
                end else begin
                    cmd.dabble = 1'b1;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros but always keep the final digit.
                if (status.top_zero && !status.one_left) begin
                    cmd.shift = 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.shift = 1'b1;
                    if (status.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/uad_dp.sv
// ----------------------------------------------------------------------------
// uad_dp: digit datapath
// Holds the value, runs a shift-and-add-3 binary-to-BCD conversion one bit
// per cycle, and shifts left-aligned digits out most significant first.
// ----------------------------------------------------------------------------
module uad_dp (
    input  logic                aclk,
    input  uad_pkg::in_beat_t   in_beat,
    input  uad_pkg::dp_cmd_t    cmd,
    output uad_pkg::dp_status_t status,
    output uad_pkg::out_beat_t  out_beat
);

    logic [uad_pkg::VALUE_WIDTH-1:0] bin_reg;
    logic [uad_pkg::DAB_W-1:0]       dab_reg;
    logic [uad_pkg::DIG_W-1:0]       dig_reg;
    logic [uad_pkg::BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [uad_pkg::DIG_CNT_W-1:0]   dig_cnt_reg;
    logic                            upper_reg;
    logic                            dec_reg;

    logic [uad_pkg::DAB_W-1:0]       dab_adj;
    logic [3:0]                      top_digit;

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb begin
        for (int i = 0; i < uad_pkg::DEC_DIGITS; i++) begin
            if (dab_reg[i*4 +: 4] >= 4'd5) begin
                dab_adj[i*4 +: 4] = 4'(dab_reg[i*4 +: 4] + 4'd3);
            end else begin
                dab_adj[i*4 +: 4] = dab_reg[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg     <= in_beat.value;
            dab_reg     <= '0;
            bit_cnt_reg <= uad_pkg::BIT_CNT_W'(uad_pkg::VALUE_WIDTH);
            upper_reg   <= in_beat.op[1];
            dec_reg     <= (in_beat.op == uad_pkg::OP_DEC);
            if (in_beat.op == uad_pkg::OP_DEC) begin
                dig_cnt_reg <= uad_pkg::DIG_CNT_W'(uad_pkg::DEC_DIGITS);
            end else begin
                dig_reg     <= uad_pkg::DIG_W'(in_beat.value)
                               << (uad_pkg::DIG_W - uad_pkg::HEX_DIGITS * 4);
                dig_cnt_reg <= uad_pkg::DIG_CNT_W'(uad_pkg::HEX_DIGITS);
            end
        end
        if (cmd.dabble) begin
            {dab_reg, bin_reg} <= {dab_adj[uad_pkg::DAB_W-2:0], bin_reg, 1'b0};
            bit_cnt_reg        <= bit_cnt_reg - 1'b1;
        end
        if (cmd.align) begin
            dig_reg <= uad_pkg::DIG_W'(dab_reg) << (uad_pkg::DIG_W - uad_pkg::DAB_W);
        end
        if (cmd.shift) begin
            dig_reg     <= dig_reg << 4;
            dig_cnt_reg <= dig_cnt_reg - 1'b1;
        end
    end

    assign top_digit = dig_reg[uad_pkg::DIG_W-1 -: 4];

    always_comb begin
        status.is_dec    = dec_reg;
        status.bits_done = (bit_cnt_reg == '0);
        status.top_zero  = (top_digit == 4'd0);
        status.one_left  = (dig_cnt_reg == uad_pkg::DIG_CNT_W'(1));

        out_beat.character = uad_pkg::digit_to_ascii(top_digit, upper_reg);
        out_beat.last      = (dig_cnt_reg == uad_pkg::DIG_CNT_W'(1));
    end

endmodule

### tb/tb_unsigned_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// tb_unsigned_to_ascii_digits: self-checking bench for the digit converter
// Feeds values in all three modes, plus the undefined mode, with random gaps
// on the input and random back-pressure on the output. Every output beat is
// compared against characters spelled out independently by the bench.
// ----------------------------------------------------------------------------
module tb_unsigned_to_ascii_digits;

    // Mode 3 has no name in the package; the block treats it as uppercase hex.
    localparam logic [1:0] OP_HEX_ALT   = 2'd3;
    localparam logic [6:0] CH_ZERO_CHAR = uad_pkg::ASCII_ZERO;
    localparam logic [6:0] CH_LOWER_A   = 7'h61;
    localparam logic [6:0] CH_UPPER_A   = 7'h41;
    localparam int         IDLE_PCT     = 33;
    localparam int         RANDOM_ITEMS = 256;
    localparam int         DRAIN_CYCLES = 60;
    localparam int         DRAIN_LIMIT  = 20000;

    class digit_checker;
        uad_pkg::out_beat_t pending_chars[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Spell the value out least significant digit first, then queue the
        // characters in reverse so the most significant comes out first.
        function void spell_value(uad_pkg::in_beat_t b);
            logic [3:0]                      digits[uad_pkg::MAX_DIGITS];
            int                              count;
            logic [uad_pkg::VALUE_WIDTH-1:0] n;
            uad_pkg::out_beat_t              c;
            n     = b.value;
            count = 0;
            if (n == '0) begin
                digits[0] = 4'd0;
                count     = 1;
            end else if (b.op == uad_pkg::OP_DEC) begin
                while (n != '0) begin
                    digits[count] = 4'(n % 10);
                    n             = n / 10;
                    count++;
                end
            end else begin
                while (n != '0) begin
                    digits[count] = n[3:0];
                    n             = n >> 4;
                    count++;
                end
            end
            for (int k = count - 1; k >= 0; k--) begin
                if (digits[k] < 4'd10) begin
                    c.character = CH_ZERO_CHAR + 7'(digits[k]);
                end else if (b.op[1]) begin
                    c.character = CH_UPPER_A + 7'(digits[k] - 4'd10);
                end else begin
                    c.character = CH_LOWER_A + 7'(digits[k] - 4'd10);
                end
                c.last = (k == 0);
                pending_chars.push_back(c);
            end
        endfunction

        task check_char(uad_pkg::out_beat_t got);
            uad_pkg::out_beat_t want;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected beat, char 0x%02h last %0b",
                                 got.character, got.last));
            end else begin
                want = pending_chars.pop_front();
                if (got.character !== want.character) begin
                    report($sformatf("char 0x%02h, wanted 0x%02h",
                                     got.character, want.character));
                end
                if (got.last !== want.last) begin
                    report($sformatf("last %0b, wanted %0b on char 0x%02h",
                                     got.last, want.last, want.character));
                end
            end
        endtask

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    uad_pkg::in_beat_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    uad_pkg::out_beat_t m_data;

    bit           no_idle = 1'b0;
    digit_checker board   = new();

    unsigned_to_ascii_digits u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Called right after a rising edge; returns right after the edge that
    // accepted the beat.
    task send_value(logic [1:0] op, logic [uad_pkg::VALUE_WIDTH-1:0] value);
        uad_pkg::in_beat_t b;
        b.op    = op;
        b.value = value;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.spell_value(b);
    endtask

    task send_random();
        logic [1:0]                      op;
        logic [uad_pkg::VALUE_WIDTH-1:0] v;
        int                              pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            op = uad_pkg::OP_DEC;
        end else if (pick < 6) begin
            op = uad_pkg::OP_HEX_LOWER;
        end else if (pick < 9) begin
            op = uad_pkg::OP_HEX_UPPER;
        end else begin
            op = OP_HEX_ALT;
        end
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom;
            end
            1: begin
                v = $urandom >> $urandom_range(0, uad_pkg::VALUE_WIDTH - 1);
            end
            2: begin
                v = $urandom_range(0, 20);
            end
            default: begin
                // Digit-count boundaries: a power of two or one below it.
                v = 32'd1 << $urandom_range(0, uad_pkg::VALUE_WIDTH - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = v - 1;
                end
            end
        endcase
        send_value(op, v);
    endtask

    // Output side: random back-pressure, and every accepted beat is checked.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_char(m_data);
            end
            m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero in every mode gives a single '0'.
        send_value(uad_pkg::OP_DEC, 32'd0);
        send_value(uad_pkg::OP_HEX_LOWER, 32'd0);
        send_value(uad_pkg::OP_HEX_UPPER, 32'd0);
        send_value(OP_HEX_ALT, 32'd0);
        // Full-scale value: ten decimal digits, eight hex digits.
        send_value(uad_pkg::OP_DEC, 32'hFFFF_FFFF);
        send_value(uad_pkg::OP_HEX_LOWER, 32'hFFFF_FFFF);
        send_value(uad_pkg::OP_HEX_UPPER, 32'hFFFF_FFFF);
        send_value(OP_HEX_ALT, 32'hFFFF_FFFF);
        send_value(uad_pkg::OP_DEC, 32'd1);
        send_value(uad_pkg::OP_HEX_LOWER, 32'd1);
        send_value(uad_pkg::OP_DEC, 32'd9);
        send_value(uad_pkg::OP_DEC, 32'd10);
        send_value(uad_pkg::OP_DEC, 32'd999_999_999);
        send_value(uad_pkg::OP_DEC, 32'd1_000_000_000);
        send_value(uad_pkg::OP_HEX_LOWER, 32'h0000_000F);
        send_value(uad_pkg::OP_HEX_UPPER, 32'h0000_0010);
        send_value(uad_pkg::OP_HEX_LOWER, 32'hDEAD_BEEF);
        send_value(uad_pkg::OP_HEX_UPPER, 32'hDEAD_BEEF);
        send_value(OP_HEX_ALT, 32'hABCD_EF01);
        send_value(uad_pkg::OP_DEC, 32'h8000_0000);
        send_value(uad_pkg::OP_HEX_UPPER, 32'h8000_0000);
        send_value(uad_pkg::OP_HEX_LOWER, 32'h0000_000A);
        send_value(uad_pkg::OP_HEX_UPPER, 32'h0123_4567);
        send_value(uad_pkg::OP_DEC, 32'd1_234_567_890);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 120 && i < 180);
            send_random();
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        waited = 0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.pending() != 0) begin
            board.report($sformatf("%0d characters never arrived", board.pending()));
        end
        if (board.errors == 0) begin
            $display("tb_unsigned_to_ascii_digits: clean");
        end else begin
            $display("tb_unsigned_to_ascii_digits: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_unsigned_to_ascii_digits: errors");
        $finish;
    end

endmodule
